// ----- sv/i2cms_pkg.sv -----
// Shared codes, defaults and control structs for the I2C master transaction sequencer.
package i2cms_pkg;

    localparam int unsigned TX_DEPTH_DEF = 16;
    localparam int unsigned RX_DEPTH_DEF = 16;

    // Commands
    localparam logic [2:0] CMD_BEGIN_WR = 3'd0;
    localparam logic [2:0] CMD_QUEUE    = 3'd1;
    localparam logic [2:0] CMD_LAUNCH   = 3'd2;
    localparam logic [2:0] CMD_BEGIN_RD = 3'd3;
    localparam logic [2:0] CMD_EVENT    = 3'd4;
    localparam logic [2:0] CMD_POP      = 3'd5;

    // Bus status events
    localparam logic [3:0] EV_START        = 4'd0;
    localparam logic [3:0] EV_REP_START    = 4'd1;
    localparam logic [3:0] EV_WR_ADDR_ACK  = 4'd2;
    localparam logic [3:0] EV_WR_DATA_ACK  = 4'd3;
    localparam logic [3:0] EV_WR_ADDR_NACK = 4'd4;
    localparam logic [3:0] EV_WR_DATA_NACK = 4'd5;
    localparam logic [3:0] EV_ARB_LOST     = 4'd6;
    localparam logic [3:0] EV_RD_DATA_ACK  = 4'd7;
    localparam logic [3:0] EV_RD_ADDR_ACK  = 4'd8;
    localparam logic [3:0] EV_RD_ADDR_NACK = 4'd9;
    localparam logic [3:0] EV_RD_DATA_NACK = 4'd10;
    localparam logic [3:0] EV_OTHER        = 4'd11;

    // Bus actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_RX_ACK  = 3'd3;
    localparam logic [2:0] ACT_RX_NACK = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;
    localparam logic [2:0] ACT_RELEASE = 3'd6;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic       restart;
        logic       advance;
        logic [7:0] data;
    } t_tx_ctl;

    typedef struct packed {
        logic       can_send;
        logic [7:0] head;
    } t_tx_stat;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic       pop;
        logic [4:0] len;
        logic [7:0] data;
    } t_rx_ctl;

    typedef struct packed {
        logic       can_pop;
        logic       avail;
        logic       more;
        logic [7:0] head;
    } t_rx_stat;

endpackage

// ----- sv/i2cms_tx_queue.sv -----
// Transmit byte queue: store, fill and send counts, registered head read.
module i2cms_tx_queue #(
    parameter int unsigned DEPTH = i2cms_pkg::TX_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cms_pkg::t_tx_ctl   i_ctl,
    output i2cms_pkg::t_tx_stat  o_stat
);
    import i2cms_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_head;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_send, n_send;
    logic [AW-1:0] w_rd_idx;
    logic          w_push_ok;

    assign w_push_ok = i_ctl.push && (r_fill < CW'(DEPTH));

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (w_push_ok) begin
            n_fill = r_fill + CW'(1);
        end
        n_send = r_send;
        if (i_ctl.restart) begin
            n_send = '0;
        end else if (i_ctl.advance) begin
            n_send = r_send + CW'(1);
        end
    end

    assign w_rd_idx = (n_send < CW'(DEPTH)) ? n_send[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_send <= '0;
        end else begin
            r_fill <= n_fill;
            r_send <= n_send;
        end
    end

    // Pre-read the byte at the next send position; forward a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_fill[AW-1:0]] <= i_ctl.data;
        end
        if (w_push_ok && (r_fill[AW-1:0] == w_rd_idx)) begin
            r_head <= i_ctl.data;
        end else begin
            r_head <= r_mem[w_rd_idx];
        end
    end

    assign o_stat.can_send = (r_send < r_fill);
    assign o_stat.head     = r_head;

endmodule

// ----- sv/i2cms_rx_queue.sv -----
// Receive byte queue: store, fill, take and last counts, registered head read.
module i2cms_rx_queue #(
    parameter int unsigned DEPTH = i2cms_pkg::RX_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cms_pkg::t_rx_ctl   i_ctl,
    output i2cms_pkg::t_rx_stat  o_stat
);
    import i2cms_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = (CW > 5) ? CW : 5;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_head;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_take, n_take;
    logic [AW-1:0] r_last, n_last;
    logic [LW-1:0] w_len;
    logic [AW-1:0] w_rd_idx;
    logic          w_push_ok;
    logic          w_can_pop;

    assign w_push_ok = i_ctl.push && (r_fill < CW'(DEPTH));
    assign w_can_pop = (r_take < r_fill);

    // Clamp the requested length into one to the store depth
    always_comb begin
        w_len = LW'(i_ctl.len);
        if (w_len == '0) begin
            w_len = LW'(1);
        end else if (w_len > LW'(DEPTH)) begin
            w_len = LW'(DEPTH);
        end
    end

    always_comb begin
        n_fill = r_fill;
        n_take = r_take;
        n_last = r_last;
        if (i_ctl.clear) begin
            n_fill = '0;
            n_take = '0;
            n_last = AW'(w_len - LW'(1));
        end else begin
            if (w_push_ok) begin
                n_fill = r_fill + CW'(1);
            end
            if (i_ctl.pop && w_can_pop) begin
                n_take = r_take + CW'(1);
            end
        end
    end

    assign w_rd_idx = (n_take < CW'(DEPTH)) ? n_take[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_take <= '0;
            r_last <= '0;
        end else begin
            r_fill <= n_fill;
            r_take <= n_take;
            r_last <= n_last;
        end
    end

    // Pre-read the byte at the next take position; forward a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_fill[AW-1:0]] <= i_ctl.data;
        end
        if (w_push_ok && (r_fill[AW-1:0] == w_rd_idx)) begin
            r_head <= i_ctl.data;
        end else begin
            r_head <= r_mem[w_rd_idx];
        end
    end

    assign o_stat.can_pop = w_can_pop;
    assign o_stat.avail   = (n_take != n_fill);
    assign o_stat.more    = (n_fill != CW'(r_last));
    assign o_stat.head    = r_head;

endmodule

// ----- sv/i2c_master_transaction_sequencer_core.sv -----
// An accepted item is held in the input register and passes to the result register,
// where o_valid is high, once that register is empty or its result is being taken.
// Throughput: one item per cycle while i_ready stays high; the queues pre-read their head
// byte each cycle. Input and result registers part the two handshakes: a waiting result
// still lets one transfer into the input register, and o_ready drops while both are full.
// Reset (synchronous, active low) empties both queues, clears busy and hold,
// sets address-acknowledged, and drops both valid flags; no clearing pass.
module i2c_master_transaction_sequencer_core #(
    parameter int unsigned TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF,
    parameter int unsigned RX_DEPTH = i2cms_pkg::RX_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_cmd,
    input  logic [6:0] i_target_address,
    input  logic [7:0] i_data_byte,
    input  logic       i_hold_bus,
    input  logic [4:0] i_read_length,
    input  logic [3:0] i_bus_event,
    input  logic [7:0] i_received_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_bus_action,
    output logic [7:0] o_send_byte,
    output logic       o_busy_res,
    output logic       o_address_acked,
    output logic       o_rx_available,
    output logic [7:0] o_rx_data,
    output logic       o_rejected
);
    import i2cms_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [2:0] r_cmd;
    logic [6:0] r_addr;
    logic [7:0] r_data;
    logic       r_hold_in;
    logic [4:0] r_len;
    logic [3:0] r_ev;
    logic [7:0] r_rbyte;

    // Sequencer state
    logic [7:0] r_addr_dir, n_addr_dir;
    logic       r_hold, n_hold;
    logic       r_busy, n_busy;
    logic       r_acked, n_acked;

    // Result register
    logic       r_out_valid;
    logic [2:0] r_action;
    logic [7:0] r_sbyte;
    logic       r_busy_out;
    logic       r_acked_out;
    logic       r_avail_out;
    logic [7:0] r_popped;
    logic       r_rej;

    logic       w_adv;
    logic [2:0] w_action;
    logic [7:0] w_sbyte;
    logic [7:0] w_popped;
    logic       w_rej;

    t_tx_ctl  w_tx_ctl;
    t_tx_stat w_tx_stat;
    t_rx_ctl  w_rx_ctl;
    t_rx_stat w_rx_stat;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd     <= i_cmd;
            r_addr    <= i_target_address;
            r_data    <= i_data_byte;
            r_hold_in <= i_hold_bus;
            r_len     <= i_read_length;
            r_ev      <= i_bus_event;
            r_rbyte   <= i_received_byte;
        end
    end

    i2cms_tx_queue #(
        .DEPTH (TX_DEPTH)
    ) u_tx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tx_ctl),
        .o_stat  (w_tx_stat)
    );

    i2cms_rx_queue #(
        .DEPTH (RX_DEPTH)
    ) u_rx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_rx_ctl),
        .o_stat  (w_rx_stat)
    );

    // Decide the action for the held item; queue controls act only on advance
    always_comb begin
        n_addr_dir = r_addr_dir;
        n_hold     = r_hold;
        n_busy     = r_busy;
        n_acked    = r_acked;
        w_action   = ACT_NONE;
        w_sbyte    = 8'd0;
        w_popped   = 8'd0;
        w_rej      = 1'b0;

        w_tx_ctl         = '0;
        w_tx_ctl.data    = r_data;
        w_rx_ctl         = '0;
        w_rx_ctl.len     = r_len;
        w_rx_ctl.data    = r_rbyte;

        if (w_adv) begin
            case (r_cmd)
                CMD_BEGIN_WR: begin
                    if (r_busy) begin
                        w_rej = 1'b1;
                    end else begin
                        w_tx_ctl.clear = 1'b1;
                        n_addr_dir     = {r_addr, 1'b0};
                        n_acked        = 1'b1;
                    end
                end
                CMD_QUEUE: begin
                    w_tx_ctl.push = 1'b1;
                end
                CMD_LAUNCH: begin
                    if (r_busy) begin
                        w_rej = 1'b1;
                    end else begin
                        n_hold           = r_hold_in;
                        w_tx_ctl.restart = 1'b1;
                        n_busy           = 1'b1;
                        w_action         = ACT_START;
                    end
                end
                CMD_BEGIN_RD: begin
                    if (r_busy) begin
                        w_rej = 1'b1;
                    end else begin
                        w_tx_ctl.clear = 1'b1;
                        w_rx_ctl.clear = 1'b1;
                        n_addr_dir     = {r_addr, 1'b1};
                        n_acked        = 1'b1;
                        n_busy         = 1'b1;
                        w_action       = ACT_START;
                    end
                end
                CMD_EVENT: begin
                    case (r_ev)
                        EV_START, EV_REP_START: begin
                            w_action = ACT_SEND;
                            w_sbyte  = r_addr_dir;
                        end
                        EV_WR_ADDR_ACK, EV_WR_DATA_ACK: begin
                            if (w_tx_stat.can_send) begin
                                w_action         = ACT_SEND;
                                w_sbyte          = w_tx_stat.head;
                                w_tx_ctl.advance = 1'b1;
                            end else if (r_hold) begin
                                n_hold   = 1'b0;
                                n_busy   = 1'b0;
                                w_action = ACT_RELEASE;
                            end else begin
                                n_busy   = 1'b0;
                                w_action = ACT_STOP;
                            end
                        end
                        EV_WR_ADDR_NACK: begin
                            n_acked  = 1'b0;
                            n_busy   = 1'b0;
                            w_action = ACT_STOP;
                        end
                        EV_WR_DATA_NACK, EV_RD_ADDR_NACK: begin
                            n_busy   = 1'b0;
                            w_action = ACT_STOP;
                        end
                        EV_RD_DATA_ACK: begin
                            w_rx_ctl.push = 1'b1;
                            w_action = w_rx_stat.more ? ACT_RX_ACK : ACT_RX_NACK;
                        end
                        EV_RD_ADDR_ACK: begin
                            w_action = w_rx_stat.more ? ACT_RX_ACK : ACT_RX_NACK;
                        end
                        EV_RD_DATA_NACK: begin
                            w_rx_ctl.push = 1'b1;
                            n_busy        = 1'b0;
                            w_action      = ACT_STOP;
                        end
                        default: begin
                            // arbitration lost, other and unused codes: hold everything
                            w_action = ACT_NONE;
                        end
                    endcase
                end
                CMD_POP: begin
                    w_rx_ctl.pop = 1'b1;
                    if (w_rx_stat.can_pop) begin
                        w_popped = w_rx_stat.head;
                    end
                end
                default: begin
                    w_action = ACT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_dir <= '0;
            r_hold     <= 1'b0;
            r_busy     <= 1'b0;
            r_acked    <= 1'b1;
        end else begin
            r_addr_dir <= n_addr_dir;
            r_hold     <= n_hold;
            r_busy     <= n_busy;
            r_acked    <= n_acked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_action    <= w_action;
            r_sbyte     <= w_sbyte;
            r_busy_out  <= n_busy;
            r_acked_out <= n_acked;
            r_avail_out <= w_rx_stat.avail;
            r_popped    <= w_popped;
            r_rej       <= w_rej;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_bus_action    = r_action;
    assign o_send_byte     = r_sbyte;
    assign o_busy_res      = r_busy_out;
    assign o_address_acked = r_acked_out;
    assign o_rx_available  = r_avail_out;
    assign o_rx_data       = r_popped;
    assign o_rejected      = r_rej;

    a_rej_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rej) |-> (r_action == ACT_NONE))
        else $error("rejected command produced a bus action");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (w_action == ACT_START)) |=> (r_busy && r_busy_out))
        else $error("start issued without entering busy");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && ((w_action == ACT_STOP) || (w_action == ACT_RELEASE))) |=> !r_busy)
        else $error("stop or release left the sequencer busy");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("input taken while the result stage was stalled");

endmodule
